@@ sv/bvfa_pkg.sv @@
`default_nettype none

package bvfa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = 64;
    localparam int PAIR_BITS  = 2 * WORD_BITS;
    localparam int BANK_DEPTH = NUM_WORDS / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int OFF_W      = $clog2(WORD_BITS);

    // Fixed field widths of the access word
    localparam int IDX_W = 11;
    localparam int LEN_W = 6;
    localparam int VAL_W = 32;
    localparam int BLEN_W = 12;

    localparam logic [BLEN_W-1:0] VEC_BITS   = BLEN_W'(NUM_WORDS * WORD_BITS);
    localparam logic [BLEN_W-1:0] BLEN_RESET = 12'd2048;
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(WORD_BITS < 32 ? WORD_BITS : 32);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 hi_en;
        logic                 lo_en;
        logic [WORD_BITS-1:0] hi_data;
        logic [WORD_BITS-1:0] lo_data;
    } bvfa_wr_t;

endpackage

`default_nettype wire

@@ sv/bvfa_bank.sv @@
`default_nettype none

module bvfa_bank (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [bvfa_pkg::BANK_AW-1:0]  rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [bvfa_pkg::BANK_AW-1:0]  wr_addr,
    input  wire logic [bvfa_pkg::WORD_BITS-1:0] wr_data,
    output logic      [bvfa_pkg::WORD_BITS-1:0] rd_data
);

    logic [bvfa_pkg::WORD_BITS-1:0]  mem_array [bvfa_pkg::BANK_DEPTH];
    logic [bvfa_pkg::BANK_DEPTH-1:0] vld_reg;
    logic [bvfa_pkg::WORD_BITS-1:0]  mem_q_reg;
    logic                            vld_q_reg;
    logic                            byp_reg;
    logic [bvfa_pkg::WORD_BITS-1:0]  byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem_array[rd_addr];
        end
    end

    // Words never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
                byp_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (byp_reg)
        begin
            rd_data = byp_data_reg;
        end
        else if (vld_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

@@ sv/bvfa_merge.sv @@
`default_nettype none

module bvfa_merge (
    input  wire logic                            op,
    input  wire logic                            err,
    input  wire logic [bvfa_pkg::OFF_W-1:0]      off,
    input  wire logic [bvfa_pkg::LEN_W-1:0]      len,
    input  wire logic [bvfa_pkg::VAL_W-1:0]      val,
    input  wire logic [bvfa_pkg::WORD_BITS-1:0]  hi_word,
    input  wire logic [bvfa_pkg::WORD_BITS-1:0]  lo_word,
    output logic      [bvfa_pkg::VAL_W-1:0]      rd_value,
    output bvfa_pkg::bvfa_wr_t                   wr
);

    logic [bvfa_pkg::PAIR_BITS-1:0] pair;
    logic [bvfa_pkg::PAIR_BITS-1:0] shifted;
    logic [bvfa_pkg::PAIR_BITS-1:0] mask_pos;
    logic [bvfa_pkg::PAIR_BITS-1:0] val_pos;
    logic [bvfa_pkg::PAIR_BITS-1:0] merged;
    logic [bvfa_pkg::WORD_BITS-1:0] fmask;
    logic [bvfa_pkg::WORD_BITS-1:0] fval;
    logic [bvfa_pkg::LEN_W-1:0]     rsh;
    logic [bvfa_pkg::WORD_BITS-1:0] field;
    logic                           do_wr;

    always_comb
    begin
        pair    = {hi_word, lo_word};
        rsh     = bvfa_pkg::LEN_W'(bvfa_pkg::WORD_BITS) - len;
        // Left-align the field, then drop it to the bottom
        shifted = pair << off;
        field   = shifted[bvfa_pkg::PAIR_BITS-1 -: bvfa_pkg::WORD_BITS] >> rsh;
        // High-aligned mask and value, slid down to the field position
        fmask    = {bvfa_pkg::WORD_BITS{1'b1}} << rsh;
        fval     = bvfa_pkg::WORD_BITS'(val) << rsh;
        mask_pos = {fmask, {bvfa_pkg::WORD_BITS{1'b0}}} >> off;
        val_pos  = {fval, {bvfa_pkg::WORD_BITS{1'b0}}} >> off;
        merged   = (pair & ~mask_pos) | (val_pos & mask_pos);

        do_wr = (op == bvfa_pkg::OP_WRITE) && !err;
        rd_value = ((op == bvfa_pkg::OP_READ) && !err) ? bvfa_pkg::VAL_W'(field) : '0;

        wr.hi_en   = do_wr && (|mask_pos[bvfa_pkg::PAIR_BITS-1 -: bvfa_pkg::WORD_BITS]);
        wr.lo_en   = do_wr && (|mask_pos[bvfa_pkg::WORD_BITS-1:0]);
        wr.hi_data = merged[bvfa_pkg::PAIR_BITS-1 -: bvfa_pkg::WORD_BITS];
        wr.lo_data = merged[bvfa_pkg::WORD_BITS-1:0];
    end

endmodule

`default_nettype wire

@@ sv/bit_vector_field_access.sv @@
`default_nettype none

// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------------------
// in        in_valid / in_stall   operation, bit_index, field_len, write_value
// out       out_valid / out_stall read_value, range_error
// config    cfg_wr_en             cfg_wr_data (bit_length)
//
// One word is taken per cycle while in_stall is low.
// Stage one reads the two words the field touches from the even and odd banks;
// stage two extracts or merges and writes back, and loads the result register.
// A write back that meets a read of the same bank entry is forwarded.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// Output stall holds stage two; the input stalls only when stage one is full.

module bit_vector_field_access (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bvfa_pkg::BLEN_W-1:0]   cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [bvfa_pkg::IDX_W-1:0]    bit_index,
    input  wire logic [bvfa_pkg::LEN_W-1:0]    field_len,
    input  wire logic [bvfa_pkg::VAL_W-1:0]    write_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [bvfa_pkg::VAL_W-1:0]    read_value,
    output logic                               range_error
);

    // Configuration
    logic [bvfa_pkg::BLEN_W-1:0] bit_length_reg;
    logic [bvfa_pkg::BLEN_W-1:0] eff_len;

    // Stage one
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_op_reg;
    logic                          s1_err_reg;
    logic [bvfa_pkg::OFF_W-1:0]    s1_off_reg;
    logic [bvfa_pkg::LEN_W-1:0]    s1_len_reg;
    logic [bvfa_pkg::VAL_W-1:0]    s1_val_reg;
    logic                          s1_par_reg;
    logic [bvfa_pkg::BANK_AW-1:0]  s1_ea_reg;
    logic [bvfa_pkg::BANK_AW-1:0]  s1_oa_reg;

    // Result
    logic                          out_valid_reg, out_valid_next;
    logic [bvfa_pkg::VAL_W-1:0]    read_value_reg;
    logic                          range_error_reg;

    logic                          in_acc;
    logic                          adv;
    logic [bvfa_pkg::WORD_AW-1:0]  w0;
    logic [bvfa_pkg::WORD_AW-1:0]  w1;
    logic [bvfa_pkg::BANK_AW-1:0]  ea;
    logic [bvfa_pkg::BANK_AW-1:0]  oa;
    logic [bvfa_pkg::BLEN_W-1:0]   end_pos;
    logic                          err;

    logic [bvfa_pkg::WORD_BITS-1:0] even_rd;
    logic [bvfa_pkg::WORD_BITS-1:0] odd_rd;
    logic [bvfa_pkg::WORD_BITS-1:0] hi_word;
    logic [bvfa_pkg::WORD_BITS-1:0] lo_word;
    logic [bvfa_pkg::VAL_W-1:0]     mg_value;
    bvfa_pkg::bvfa_wr_t             mg_wr;

    logic                           even_we;
    logic                           odd_we;
    logic [bvfa_pkg::WORD_BITS-1:0] even_wd;
    logic [bvfa_pkg::WORD_BITS-1:0] odd_wd;

    // Handshake: advance stage two unless the result register is held
    always_comb
    begin
        adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = s1_valid_reg && !adv;
        in_acc   = in_valid && !in_stall;
    end

    // Address split and range check on the incoming word
    always_comb
    begin
        eff_len = (bit_length_reg < bvfa_pkg::VEC_BITS) ? bit_length_reg : bvfa_pkg::VEC_BITS;
        end_pos = bvfa_pkg::BLEN_W'(bit_index) + bvfa_pkg::BLEN_W'(field_len);
        err     = (field_len > bvfa_pkg::MAX_LEN) || (end_pos > eff_len);
        w0      = bit_index[bvfa_pkg::IDX_W-1 -: bvfa_pkg::WORD_AW];
        w1      = w0 + bvfa_pkg::WORD_AW'(1);
        // The even bank holds whichever of the two words is even
        ea      = w0[0] ? w1[bvfa_pkg::WORD_AW-1:1] : w0[bvfa_pkg::WORD_AW-1:1];
        oa      = w0[bvfa_pkg::WORD_AW-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_length_reg <= bvfa_pkg::BLEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            bit_length_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one payload: hold while stage two is stalled
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg  <= operation;
            s1_err_reg <= err;
            s1_off_reg <= bit_index[bvfa_pkg::OFF_W-1:0];
            s1_len_reg <= field_len;
            s1_val_reg <= write_value;
            s1_par_reg <= w0[0];
            s1_ea_reg  <= ea;
            s1_oa_reg  <= oa;
        end
    end

    bvfa_bank u_even (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (ea),
        .wr_en   (even_we),
        .wr_addr (s1_ea_reg),
        .wr_data (even_wd),
        .rd_data (even_rd)
    );

    bvfa_bank u_odd (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (oa),
        .wr_en   (odd_we),
        .wr_addr (s1_oa_reg),
        .wr_data (odd_wd),
        .rd_data (odd_rd)
    );

    // Put the first word of the field on top
    always_comb
    begin
        hi_word = s1_par_reg ? odd_rd : even_rd;
        lo_word = s1_par_reg ? even_rd : odd_rd;
    end

    bvfa_merge u_merge (
        .op       (s1_op_reg),
        .err      (s1_err_reg),
        .off      (s1_off_reg),
        .len      (s1_len_reg),
        .val      (s1_val_reg),
        .hi_word  (hi_word),
        .lo_word  (lo_word),
        .rd_value (mg_value),
        .wr       (mg_wr)
    );

    // Route merged words back to their banks; commit only on advance
    always_comb
    begin
        even_we = adv && (s1_par_reg ? mg_wr.lo_en : mg_wr.hi_en);
        odd_we  = adv && (s1_par_reg ? mg_wr.hi_en : mg_wr.lo_en);
        even_wd = s1_par_reg ? mg_wr.lo_data : mg_wr.hi_data;
        odd_wd  = s1_par_reg ? mg_wr.hi_data : mg_wr.lo_data;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            read_value_reg  <= mg_value;
            range_error_reg <= s1_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign range_error = range_error_reg;

    // Input only stalls behind a held stage one
    a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with stage one empty");

    // Rejected accesses never touch the store
    a_no_write_on_err : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_err_reg) |-> (!even_we && !odd_we))
        else $error("store written by rejected access");

    // Rejected accesses report zero
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (read_value == '0))
        else $error("nonzero value on rejected access");

    // A write back implies an item leaving stage one
    a_write_adv : assert property (@(posedge clk) disable iff (!rst_n)
        (even_we || odd_we) |=> out_valid_reg)
        else $error("write back without a result");

endmodule

`default_nettype wire

@@ tb/bvfa_checker.sv @@
`timescale 1ns / 100ps

module bvfa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bvfa_pkg::BLEN_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          operation,
    input  logic [bvfa_pkg::IDX_W-1:0]    bit_index,
    input  logic [bvfa_pkg::LEN_W-1:0]    field_len,
    input  logic [bvfa_pkg::VAL_W-1:0]    write_value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [bvfa_pkg::VAL_W-1:0]    read_value,
    input  logic                          range_error,
    output int                            fail_count,
    output int                            pending
);

    localparam int VECTOR_BITS  = bvfa_pkg::NUM_WORDS * bvfa_pkg::WORD_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [bvfa_pkg::VAL_W-1:0] value;
        logic                       err;
    } field_result_t;

    logic [bvfa_pkg::WORD_BITS-1:0] vec_words [bvfa_pkg::NUM_WORDS];
    logic [bvfa_pkg::BLEN_W-1:0]    length_reg;
    field_result_t                  field_results_q [$];
    int                             reported;

    // Apply one access to the vector copy and return the result word it yields.
    function automatic field_result_t access_field(
        logic                       op,
        logic [bvfa_pkg::IDX_W-1:0] idx,
        logic [bvfa_pkg::LEN_W-1:0] len,
        logic [bvfa_pkg::VAL_W-1:0] val
    );
        field_result_t res;
        int            limit;
        int            pos;
        res   = '0;
        limit = (int'(length_reg) < VECTOR_BITS) ? int'(length_reg) : VECTOR_BITS;
        if (len > bvfa_pkg::MAX_LEN || int'(idx) + int'(len) > limit)
        begin
            res.err = 1'b1;
            return res;
        end
        for (int i = 0; i < int'(len); i++)
        begin
            pos = int'(idx) + i;
            if (op == bvfa_pkg::OP_READ)
                res.value = {res.value[bvfa_pkg::VAL_W-2:0],
                             vec_words[pos / bvfa_pkg::WORD_BITS]
                                      [bvfa_pkg::WORD_BITS - 1 - pos % bvfa_pkg::WORD_BITS]};
            else
                vec_words[pos / bvfa_pkg::WORD_BITS]
                         [bvfa_pkg::WORD_BITS - 1 - pos % bvfa_pkg::WORD_BITS] =
                    val[int'(len) - 1 - i];
        end
        return res;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (reported < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        reported++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_result_t exp_res;
        if (!rst_n)
        begin
            for (int w = 0; w < bvfa_pkg::NUM_WORDS; w++)
                vec_words[w] = '0;
            length_reg = bvfa_pkg::BLEN_RESET;
            field_results_q.delete();
            fail_count = 0;
            reported   = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                length_reg = cfg_wr_data;
            // Predict first, so a result leaving at this edge still meets the oldest entry.
            if (in_valid && !in_stall)
                field_results_q.push_back(
                    access_field(operation, bit_index, field_len, write_value));
            if (out_valid && !out_stall)
            begin
                if (field_results_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected result word read_value=%h range_error=%b",
                                           read_value, range_error));
                end
                else
                begin
                    exp_res = field_results_q.pop_front();
                    if (read_value !== exp_res.value)
                        note_failure($sformatf("read_value expected %h actual %h",
                                               exp_res.value, read_value));
                    if (range_error !== exp_res.err)
                        note_failure($sformatf("range_error expected %b actual %b",
                                               exp_res.err, range_error));
                end
            end
            pending = field_results_q.size();
        end
    end

endmodule

@@ tb/bit_vector_field_access_tb.sv @@
`timescale 1ns / 100ps

module bit_vector_field_access_tb;

    // Generous ceiling: roughly 2000 words at one per cycle, with both sides
    // idling now and then, finish well inside it.
    localparam int LIMIT_CYCLES = 200_000;
    localparam int VECTOR_BITS  = bvfa_pkg::NUM_WORDS * bvfa_pkg::WORD_BITS;
    localparam int IDLE_PERCENT = 6;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [bvfa_pkg::BLEN_W-1:0] cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic                        operation   = bvfa_pkg::OP_READ;
    logic [bvfa_pkg::IDX_W-1:0]  bit_index   = '0;
    logic [bvfa_pkg::LEN_W-1:0]  field_len   = '0;
    logic [bvfa_pkg::VAL_W-1:0]  write_value = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [bvfa_pkg::VAL_W-1:0]  read_value;
    logic                        range_error;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int cur_len     = int'(bvfa_pkg::BLEN_RESET);   // mirror of bit_length, used only to aim stimulus
    bit quiet       = 1'b0;                         // high: neither side idles

    bit_vector_field_access u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .bit_index   (bit_index),
        .field_len   (field_len),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .range_error (range_error)
    );

    bvfa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .bit_index   (bit_index),
        .field_len   (field_len),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .range_error (range_error),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if the handshakes never settle.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("** bit_vector_field_access: FAILED **");
            $finish;
        end
    end

    // Receiver side: stall the result channel at random, except in the quiet stretch.
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Send one access word. Idle a random number of cycles first, then hold
    // the word until the block takes it. Return at the accepting rising edge,
    // with valid still high so back-to-back words need no second assignment.
    task automatic send_access(logic op, int idx, int len, logic [bvfa_pkg::VAL_W-1:0] val);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        bit_index   <= idx[bvfa_pkg::IDX_W-1:0];
        field_len   <= len[bvfa_pkg::LEN_W-1:0];
        write_value <= val;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write bit_length only with the pipeline empty.
    task automatic set_bit_length(int len);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[bvfa_pkg::BLEN_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_len = len;
    endtask

    // Random accesses. Most fields fit the current vector, many of them in a
    // small hot region so reads land on earlier writes; the rest hug the end
    // of the vector, land anywhere, or are longer than a word.
    task automatic run_random_accesses(int count);
        int eff;
        int len;
        int idx;
        int pick;
        int hot;
        eff = (cur_len < VECTOR_BITS) ? cur_len : VECTOR_BITS;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                len = $urandom_range(63, 33);
                idx = $urandom_range(VECTOR_BITS - 1);
            end
            else
            begin
                len = $urandom_range(32);
                if (pick < 20 || eff < len)
                    idx = $urandom_range(VECTOR_BITS - 1);
                else if (pick < 30)
                begin
                    // Land exactly on the end, or one past it.
                    idx = eff - len + $urandom_range(1);
                    if (idx > VECTOR_BITS - 1)
                        idx = VECTOR_BITS - 1;
                end
                else if (pick < 65)
                begin
                    hot = eff - len;
                    if (hot > 127)
                        hot = 127;
                    idx = $urandom_range(hot);
                end
                else
                    idx = $urandom_range(eff - len);
            end
            send_access($urandom_range(1) ? bvfa_pkg::OP_WRITE : bvfa_pkg::OP_READ,
                        idx, len, $urandom());
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset length of 2048 bits.
        send_access(bvfa_pkg::OP_READ,     0, 32, 32'h0000_0000);   // cleared store reads zero
        send_access(bvfa_pkg::OP_WRITE,    0, 32, 32'hFFFF_FFFF);
        send_access(bvfa_pkg::OP_READ,     0, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE,   30,  8, 32'h0000_01A5);   // masking: bit 8 must not land
        send_access(bvfa_pkg::OP_READ,    24, 32, 32'h0000_0000);   // crosses into word 1
        send_access(bvfa_pkg::OP_READ,    30,  8, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE,    1,  1, 32'hFFFF_FFFE);
        send_access(bvfa_pkg::OP_READ,     0,  2, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE, 2016, 32, 32'hA5A5_A5A5);   // last word, ends on the limit
        send_access(bvfa_pkg::OP_READ,  2016, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ,  2047,  1, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE, 2047,  0, 32'hFFFF_FFFF);   // empty field
        send_access(bvfa_pkg::OP_READ,  2047,  0, 32'hFFFF_FFFF);
        send_access(bvfa_pkg::OP_READ,  2040,  9, 32'h0000_0000);   // one bit past the end
        send_access(bvfa_pkg::OP_WRITE, 2040,  9, 32'h0000_01FF);
        send_access(bvfa_pkg::OP_READ,  2016, 32, 32'h0000_0000);   // rejected write left it alone
        send_access(bvfa_pkg::OP_READ,     0, 33, 32'h0000_0000);   // field longer than a word
        send_access(bvfa_pkg::OP_WRITE,    0, 63, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ,     0, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE,   63,  2, 32'h0000_0003);   // straddles words 1 and 2
        send_access(bvfa_pkg::OP_READ,    60,  8, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE, 1000, 17, 32'h5555_5555);
        send_access(bvfa_pkg::OP_READ,   992, 32, 32'h0000_0000);

        set_bit_length(int'(bvfa_pkg::BLEN_RESET));
        run_random_accesses(215);

        // Empty vector: only an empty field at index 0 fits.
        set_bit_length(0);
        send_access(bvfa_pkg::OP_READ,  0, 0, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ,  0, 1, 32'h0000_0000);
        send_access(bvfa_pkg::OP_WRITE, 1, 0, 32'hFFFF_FFFF);
        run_random_accesses(100);

        // Largest register value, capped at the store size.
        set_bit_length(4095);
        send_access(bvfa_pkg::OP_READ, 2016, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ, 2017, 32, 32'h0000_0000);
        run_random_accesses(215);

        // Shortened vector: bits past the end keep their values for later.
        set_bit_length(100);
        send_access(bvfa_pkg::OP_READ, 2016, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ,   68, 32, 32'h0000_0000);
        send_access(bvfa_pkg::OP_READ,   69, 32, 32'h0000_0000);
        run_random_accesses(215);

        set_bit_length(1);
        run_random_accesses(100);

        set_bit_length(2047);
        send_access(bvfa_pkg::OP_READ, 2016, 31, 32'h0000_0000);
        run_random_accesses(215);

        set_bit_length(33);
        run_random_accesses(215);

        set_bit_length($urandom_range(4095));
        run_random_accesses(215);

        // Long stretch at full rate on both sides, then back to random idling.
        set_bit_length(int'(bvfa_pkg::BLEN_RESET));
        quiet = 1'b1;
        run_random_accesses(300);
        quiet = 1'b0;
        run_random_accesses(160);

        drain_results();
        // Leave room for any stray result word past the two-stage pipeline.
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("** bit_vector_field_access: PASSED **");
        else
            $display("** bit_vector_field_access: FAILED **");
        $finish;
    end

endmodule
